@@ rtl/i2cm_pkg.sv @@
`default_nettype none
package i2cm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned PHASE_W       = 5;
  localparam int unsigned LEN_SHORT     = 4;
  localparam int unsigned LEN_WRITE     = 2 * BITS_PER_BYTE + 4;
  localparam int unsigned LEN_READ      = 2 * BITS_PER_BYTE + 5;
  localparam int unsigned BIT_PHASES    = 2 * BITS_PER_BYTE;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [PHASE_W-1:0]       phase;
    cmd_t                     cmd;
    logic [BITS_PER_BYTE-1:0] shift_reg;
    logic                     ack_choice;
    logic                     ack_seen;
    logic                     scl_level;
    logic                     sda_level;
    logic                     sda_enable;
    logic [BITS_PER_BYTE-1:0] tx_hold;
  } seq_st_t;

  typedef struct packed {
    logic                     scl;
    logic                     sda_out;
    logic                     sda_drive;
    logic                     busy_res;
    logic                     done_res;
    logic [BITS_PER_BYTE-1:0] rx_byte;
    logic                     ack_bit;
  } seq_res_t;

  localparam seq_st_t ST_RESET = '{
    phase:      '0,
    cmd:        CMD_NONE,
    shift_reg:  '0,
    ack_choice: 1'b0,
    ack_seen:   1'b0,
    scl_level:  1'b1,
    sda_level:  1'b1,
    sda_enable: 1'b1,
    tx_hold:    '0
  };

endpackage
`default_nettype wire

@@ rtl/i2cm_if.sv @@
`default_nettype none
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, func, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, func, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_bit;

  modport source (output valid, scl, sda_out, sda_drive, busy_res, done_res, rx_byte,
                  ack_bit, input ready);
  modport sink   (input valid, scl, sda_out, sda_drive, busy_res, done_res, rx_byte,
                  ack_bit, output ready);
endinterface
`default_nettype wire

@@ rtl/i2cm_step.sv @@
`default_nettype none
module i2cm_step
  import i2cm_pkg::*;
(
  input  seq_st_t    st_i,
  input  logic [2:0] func,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  output seq_st_t    st_nxt,
  output seq_res_t   res
);

  seq_st_t            s;
  logic [PHASE_W-1:0] p;
  logic [PHASE_W-1:0] last_ph;
  logic               busy;
  logic               done;
  logic               drive_seen;

  always_comb begin
    s          = st_i;
    busy       = 1'b0;
    done       = 1'b0;
    last_ph    = PHASE_W'(LEN_SHORT - 1);
    drive_seen = 1'b0;

    // a new command is only taken while idle
    if (s.cmd == CMD_NONE) begin
      unique case (func) inside
        CMD_START, CMD_STOP, CMD_WRITE, CMD_READ: begin
          s.cmd        = cmd_t'(func);
          s.phase      = '0;
          s.tx_hold    = tx_byte;
          s.ack_choice = send_ack;
        end
        default: ;
      endcase
    end

    p = s.phase;

    unique case (s.cmd)
      CMD_START: begin
        if (p == PHASE_W'(0)) begin
          s.sda_enable = 1'b1;
          s.sda_level  = 1'b1;
        end else if (p == PHASE_W'(1)) s.scl_level = 1'b1;
        else if (p == PHASE_W'(2)) s.sda_level = 1'b0;
        else s.scl_level = 1'b0;
      end
      CMD_STOP: begin
        if (p == PHASE_W'(0)) begin
          s.sda_enable = 1'b1;
          s.sda_level  = 1'b0;
        end else if (p == PHASE_W'(1)) s.scl_level = 1'b0;
        else if (p == PHASE_W'(2)) s.scl_level = 1'b1;
        else s.sda_level = 1'b1;
      end
      CMD_WRITE: begin
        last_ph = PHASE_W'(LEN_WRITE - 1);
        if (p < PHASE_W'(BIT_PHASES)) begin
          if (!p[0]) begin
            s.scl_level  = 1'b0;
            s.sda_enable = 1'b1;
            // msb first: bit index counts down with the bit slot
            s.sda_level  = s.tx_hold[3'd7 - p[3:1]];
          end else begin
            s.scl_level = 1'b1;
          end
        end else if (p == PHASE_W'(BIT_PHASES)) begin
          s.scl_level = 1'b0;
          s.sda_level = 1'b0;
        end else if (p == PHASE_W'(BIT_PHASES + 1)) begin
          s.sda_enable = 1'b0;
        end else if (p == PHASE_W'(BIT_PHASES + 2)) begin
          s.scl_level = 1'b1;
          s.ack_seen  = sda_in;
        end else begin
          s.scl_level = 1'b0;
        end
      end
      CMD_READ: begin
        last_ph = PHASE_W'(LEN_READ - 1);
        if (p == PHASE_W'(0)) begin
          s.sda_enable = 1'b0;
          s.shift_reg  = '0;
        end else if (p <= PHASE_W'(BIT_PHASES)) begin
          if (p[0]) begin
            s.scl_level = 1'b0;
            s.shift_reg = {s.shift_reg[BITS_PER_BYTE-2:0], 1'b0};
          end else begin
            s.scl_level    = 1'b1;
            s.shift_reg[0] = s.shift_reg[0] | sda_in;
          end
        end else if (p == PHASE_W'(BIT_PHASES + 1)) begin
          s.scl_level  = 1'b0;
          s.sda_enable = 1'b1;
        end else if (p == PHASE_W'(BIT_PHASES + 2)) begin
          s.sda_level = ~s.ack_choice;
        end else if (p == PHASE_W'(BIT_PHASES + 3)) begin
          s.scl_level = 1'b1;
        end else begin
          s.scl_level = 1'b0;
        end
      end
      default: ;
    endcase

    busy       = (s.cmd != CMD_NONE);
    drive_seen = s.sda_enable;

    if (busy) begin
      if (p == last_ph) begin
        done = 1'b1;
        // write hands sda drive back after the ack slot
        if (s.cmd == CMD_WRITE) s.sda_enable = 1'b1;
        s.cmd   = CMD_NONE;
        s.phase = '0;
      end else begin
        s.phase = p + PHASE_W'(1);
      end
    end

    st_nxt = s;

    res.scl       = s.scl_level;
    res.sda_out   = s.sda_level;
    res.sda_drive = drive_seen;
    res.busy_res  = busy;
    res.done_res  = done;
    res.rx_byte   = s.shift_reg;
    res.ack_bit   = s.ack_seen;
  end

endmodule
`default_nettype wire

@@ rtl/i2cm_out_reg.sv @@
`default_nettype none
module i2cm_out_reg
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  seq_res_t   res,
  output logic       room,
  i2cm_out_if.source out_ch
);

  logic     valid_r;
  seq_res_t res_r;

  // refill in the same cycle the held result is taken
  assign room = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.scl       = res_r.scl;
  assign out_ch.sda_out   = res_r.sda_out;
  assign out_ch.sda_drive = res_r.sda_drive;
  assign out_ch.busy_res  = res_r.busy_res;
  assign out_ch.done_res  = res_r.done_res;
  assign out_ch.rx_byte   = res_r.rx_byte;
  assign out_ch.ack_bit   = res_r.ack_bit;

endmodule
`default_nettype wire

@@ rtl/i2c_master_byte_sequencer.sv @@
// a tick's result is registered and shown in the cycle after its transaction
// throughput: one tick per cycle, held back only while the result register is full and stalled
// each command spans 4 (start, stop), 20 (write) or 21 (read) ticks
// reset (synchronous, rst_n low): idle, scl and sda driven high, no result pending
`default_nettype none
module i2c_master_byte_sequencer
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch
);

  seq_st_t  st_r;
  seq_st_t  st_nxt;
  seq_res_t res;
  logic     room;
  logic     accept;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  i2cm_step u_step (
    .st_i     (st_r),
    .func     (in_ch.func),
    .tx_byte  (in_ch.tx_byte),
    .send_ack (in_ch.send_ack),
    .sda_in   (in_ch.sda_in),
    .st_nxt   (st_nxt),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  i2cm_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (accept),
    .res    (res),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

@@ test/tb_i2c_master_byte_sequencer.sv @@
`default_nettype none
module tb_i2c_master_byte_sequencer;
  import i2cm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_TICKS   = 1700;
  localparam int unsigned N_DIRECT  = 25;
  localparam int unsigned QUIET_MAX = 2000;
  localparam int unsigned HOLD_LEN  = 300;
  localparam int unsigned HOLD_AT   = 500;
  localparam int unsigned MAX_SHOWN = 10;

  localparam logic [2:0] FUNC_UNKNOWN_MIN = 3'd5;
  localparam logic [2:0] FUNC_MAX         = 3'd7;

  // scl, sda_out, sda_drive, busy, done, rx_byte, ack_bit
  localparam seq_res_t IDLE_LINES = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
    logic       typed;
    seq_res_t   lines;
  } tick_t;

  logic clk;
  logic rst_n;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();

  i2c_master_byte_sequencer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  tick_t       tick_q[$];
  seq_res_t    line_q[$];
  tick_t       dir_tbl [0:N_DIRECT-1];
  int unsigned n_stim;
  int unsigned n_acc;
  int unsigned n_out;
  int unsigned n_err;

  // bus model state
  logic [4:0] bus_phase;
  cmd_t       bus_cmd;
  logic [7:0] bus_rx_sr;
  logic       bus_ack_sel;
  logic       bus_ack_seen;
  logic       bus_scl;
  logic       bus_sda;
  logic       bus_sda_en;
  logic [7:0] bus_tx;

  function automatic seq_res_t predict_lines(logic [2:0] f, logic [7:0] tx, logic ack,
                                             logic sda);
    seq_res_t    r;
    logic [4:0]  ph;
    int unsigned len;
    r = '0;
    if (bus_cmd == CMD_NONE && f >= CMD_START && f <= CMD_READ) begin
      bus_cmd     = cmd_t'(f);
      bus_phase   = '0;
      bus_tx      = tx;
      bus_ack_sel = ack;
    end
    ph = bus_phase;
    if (bus_cmd != CMD_NONE) begin
      r.busy_res = 1'b1;
      case (bus_cmd)
        CMD_START: begin
          case (ph)
            5'd0: begin
              bus_sda_en = 1'b1;
              bus_sda    = 1'b1;
            end
            5'd1: bus_scl = 1'b1;
            5'd2: bus_sda = 1'b0;
            default: bus_scl = 1'b0;
          endcase
        end
        CMD_STOP: begin
          case (ph)
            5'd0: begin
              bus_sda_en = 1'b1;
              bus_sda    = 1'b0;
            end
            5'd1: bus_scl = 1'b0;
            5'd2: bus_scl = 1'b1;
            default: bus_sda = 1'b1;
          endcase
        end
        CMD_WRITE: begin
          if (ph < BIT_PHASES) begin
            if (!ph[0]) begin
              bus_scl    = 1'b0;
              bus_sda_en = 1'b1;
              bus_sda    = bus_tx[3'd7 - ph[3:1]];
            end else begin
              bus_scl = 1'b1;
            end
          end else if (ph == BIT_PHASES) begin
            bus_scl = 1'b0;
            bus_sda = 1'b0;
          end else if (ph == BIT_PHASES + 1) begin
            bus_sda_en = 1'b0;
          end else if (ph == BIT_PHASES + 2) begin
            bus_scl      = 1'b1;
            bus_ack_seen = sda;
          end else begin
            bus_scl = 1'b0;
          end
        end
        default: begin
          if (ph == 5'd0) begin
            bus_sda_en = 1'b0;
            bus_rx_sr  = '0;
          end else if (ph <= BIT_PHASES) begin
            // odd phases open a bit slot, even phases sample it
            if (ph[0]) begin
              bus_scl   = 1'b0;
              bus_rx_sr = {bus_rx_sr[6:0], 1'b0};
            end else begin
              bus_scl      = 1'b1;
              bus_rx_sr[0] = bus_rx_sr[0] | sda;
            end
          end else if (ph == BIT_PHASES + 1) begin
            bus_scl    = 1'b0;
            bus_sda_en = 1'b1;
          end else if (ph == BIT_PHASES + 2) begin
            bus_sda = !bus_ack_sel;
          end else if (ph == BIT_PHASES + 3) begin
            bus_scl = 1'b1;
          end else begin
            bus_scl = 1'b0;
          end
        end
      endcase
    end
    r.scl       = bus_scl;
    r.sda_out   = bus_sda;
    r.sda_drive = bus_sda_en;
    if (bus_cmd != CMD_NONE) begin
      len = (bus_cmd == CMD_WRITE) ? LEN_WRITE : (bus_cmd == CMD_READ) ? LEN_READ : LEN_SHORT;
      if (ph + 1 >= len) begin
        r.done_res = 1'b1;
        if (bus_cmd == CMD_WRITE) bus_sda_en = 1'b1;
        bus_cmd   = CMD_NONE;
        bus_phase = '0;
      end else begin
        bus_phase = ph + 5'd1;
      end
    end
    r.rx_byte = bus_rx_sr;
    r.ack_bit = bus_ack_seen;
    return r;
  endfunction

  function automatic string show_lines(seq_res_t r);
    return $sformatf("scl=%b sda=%b drv=%b busy=%b done=%b rx=%02h ack=%b", r.scl, r.sda_out,
                     r.sda_drive, r.busy_res, r.done_res, r.rx_byte, r.ack_bit);
  endfunction

  task automatic flag_error(string msg);
    n_err++;
    if (n_err <= MAX_SHOWN) $display("error: %s", msg);
  endtask

  function automatic void push_tick(logic [2:0] f, logic [7:0] tx, logic ack, logic sda);
    tick_t t;
    t.func     = f;
    t.tx_byte  = tx;
    t.send_ack = ack;
    t.sda_in   = sda;
    t.typed    = 1'b0;
    t.lines    = '0;
    tick_q.push_back(t);
    n_stim++;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // well-formed commands with random content, plus some noise
  function automatic void build_random();
    cmd_t        c;
    int unsigned len;
    int unsigned sda_mode;
    logic [7:0]  tx;
    logic        ack;
    logic        sda;
    logic [2:0]  f;
    while (n_stim < N_TICKS) begin
      if ($urandom_range(0, 9) < 8) begin
        c        = cmd_t'($urandom_range(CMD_START, CMD_READ));
        len      = (c == CMD_WRITE) ? LEN_WRITE : (c == CMD_READ) ? LEN_READ : LEN_SHORT;
        tx       = pick_byte();
        ack      = 1'($urandom_range(0, 1));
        sda_mode = $urandom_range(0, 3);
        for (int unsigned k = 0; k < len; k++) begin
          sda = (sda_mode == 0) ? 1'b0 : (sda_mode == 1) ? 1'b1 : 1'($urandom_range(0, 1));
          if (k == 0) f = c;
          else if ($urandom_range(0, 7) == 0) f = 3'($urandom_range(0, FUNC_MAX));
          else f = CMD_NONE;
          push_tick(f, (k == 0) ? tx : pick_byte(), (k == 0) ? ack : 1'($urandom_range(0, 1)),
                    sda);
        end
        repeat ($urandom_range(0, 2)) begin
          f = ($urandom_range(0, 1) == 0) ? CMD_NONE
            : 3'($urandom_range(FUNC_UNKNOWN_MIN, FUNC_MAX));
          push_tick(f, pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(1, 8))
          push_tick(3'($urandom_range(0, FUNC_MAX)), pick_byte(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end
    end
  endfunction

  // sender: bursts with random gaps
  tick_t       drv_tick;
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  <= $urandom_range(1, 40);
      gap_left    <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left != 0) begin
        gap_left    <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        drv_tick         <= tick_q[0];
        in_ch.func       <= tick_q[0].func;
        in_ch.tx_byte    <= tick_q[0].tx_byte;
        in_ch.send_ack   <= tick_q[0].send_ack;
        in_ch.sda_in     <= tick_q[0].sda_in;
        in_ch.valid      <= 1'b1;
        void'(tick_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern is redrawn whenever the low seven bits of its cycle counter are zero, one long hold-off
  int unsigned rcv_cyc;
  int unsigned rcv_mode;
  int unsigned hold_left;
  logic        hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rcv_cyc      <= 0;
      rcv_mode     <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      rcv_cyc <= rcv_cyc + 1;
      if (rcv_cyc[6:0] == 7'd0) rcv_mode <= $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && n_acc >= HOLD_AT) begin
        hold_done    <= 1'b1;
        hold_left    <= HOLD_LEN;
        out_ch.ready <= 1'b0;
      end else begin
        case (rcv_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= (rcv_cyc[1:0] != 2'd0);
          2: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= (rcv_cyc[1:0] == 2'd0);
        endcase
      end
    end
  end

  // prediction on input transactions, checking on output transactions
  seq_res_t want_lines;
  seq_res_t got_lines;
  seq_res_t model_lines;

  always @(posedge clk) begin
    if (!rst_n) begin
      bus_phase    = '0;
      bus_cmd      = CMD_NONE;
      bus_rx_sr    = '0;
      bus_ack_sel  = 1'b0;
      bus_ack_seen = 1'b0;
      bus_scl      = 1'b1;
      bus_sda      = 1'b1;
      bus_sda_en   = 1'b1;
      bus_tx       = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        model_lines = predict_lines(in_ch.func, in_ch.tx_byte, in_ch.send_ack, in_ch.sda_in);
        line_q.push_back(drv_tick.typed ? drv_tick.lines : model_lines);
        n_acc++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got_lines = '{out_ch.scl, out_ch.sda_out, out_ch.sda_drive, out_ch.busy_res,
                      out_ch.done_res, out_ch.rx_byte, out_ch.ack_bit};
        if (line_q.size() == 0) begin
          flag_error($sformatf("result %0d with nothing expected: %s", n_out,
                               show_lines(got_lines)));
        end else begin
          want_lines = line_q.pop_front();
          if (got_lines.scl !== want_lines.scl || got_lines.sda_out !== want_lines.sda_out ||
              got_lines.sda_drive !== want_lines.sda_drive ||
              got_lines.busy_res !== want_lines.busy_res ||
              got_lines.done_res !== want_lines.done_res ||
              got_lines.rx_byte !== want_lines.rx_byte ||
              got_lines.ack_bit !== want_lines.ack_bit)
            flag_error($sformatf("result %0d exp %s got %s", n_out, show_lines(want_lines),
                                 show_lines(got_lines)));
        end
        n_out++;
      end
    end
  end

  int unsigned quiet;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = CMD_NONE;
    in_ch.tx_byte  = '0;
    in_ch.send_ack = 1'b0;
    in_ch.sda_in   = 1'b0;
    out_ch.ready   = 1'b0;
    drv_tick       = '0;
    n_stim         = 0;
    n_acc          = 0;
    n_out          = 0;
    n_err          = 0;

    // func, tx_byte, send_ack, sda_in, typed, expected lines
    dir_tbl = '{
      '{CMD_NONE,                 8'h00, 1'b0, 1'b0, 1'b1, IDLE_LINES},
      '{FUNC_UNKNOWN_MIN,         8'hFF, 1'b1, 1'b1, 1'b1, IDLE_LINES},
      '{3'(FUNC_UNKNOWN_MIN + 1), 8'h00, 1'b0, 1'b1, 1'b1, IDLE_LINES},
      '{FUNC_MAX,                 8'hFF, 1'b1, 1'b0, 1'b1, IDLE_LINES},
      '{CMD_START, 8'hFF, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      // commands while busy are dropped
      '{CMD_STOP,  8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, '0},
      '{CMD_NONE,  8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_STOP,  8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_NONE,  8'h00, 1'b0, 1'b1, 1'b0, '0},
      '{CMD_READ,  8'hFF, 1'b1, 1'b0, 1'b0, '0},
      '{CMD_NONE,  8'h00, 1'b0, 1'b1, 1'b0, '0},
      '{CMD_WRITE, 8'h80, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{CMD_NONE,  8'h00, 1'b0, 1'b1, 1'b0, '0},
      '{CMD_READ,  8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{CMD_NONE,  8'h00, 1'b0, 1'b1, 1'b0, '0},
      '{FUNC_MAX,  8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_NONE,  8'h00, 1'b0, 1'b1, 1'b0, '0},
      '{CMD_START, 8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{CMD_NONE,  8'h00, 1'b0, 1'b1, 1'b0, '0},
      '{CMD_NONE,  8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_NONE,  8'h00, 1'b0, 1'b1, 1'b0, '0},
      '{CMD_NONE,  8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{CMD_NONE,  8'h00, 1'b0, 1'b1, 1'b0, '0},
      '{CMD_NONE,  8'h00, 1'b0, 1'b0, 1'b0, '0}
    };
    for (int unsigned i = 0; i < N_DIRECT; i++) begin
      tick_q.push_back(dir_tbl[i]);
      n_stim++;
    end
    build_random();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (n_acc != n_stim) @(posedge clk);
    while (line_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2cm_step.sv
rtl/i2cm_out_reg.sv
rtl/i2c_master_byte_sequencer.sv
test/tb_i2c_master_byte_sequencer.sv
